[sv/pid_controller_antiwindup_defines.svh]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_defines.svh
// assertion macros used by the pid controller checker
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PIDAW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define PIDAW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pidaw_pkg
// types and constants of the anti-windup pid controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidaw_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_DEADBAND    = 3'd3,
    CFG_ISOLATE_THR = 3'd4,
    CFG_INT_BOUND   = 3'd5,
    CFG_OUT_BOUND   = 3'd6,
    CFG_MODE        = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 31;

  // mode flag bit positions
  localparam int unsigned ModeDeadband  = 0;
  localparam int unsigned ModeSeparate  = 1;
  localparam int unsigned ModeIsolate   = 2;
  localparam int unsigned ModeIntClamp  = 3;
  localparam int unsigned ModeFeedfwd   = 4;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] deadband_width;
    logic        [15:0] isolate_threshold;
    logic        [30:0] integral_bound;
    logic        [14:0] output_bound;
    logic        [4:0]  mode_flags;
  } pidaw_cfg_t;

  // result flags, also the tuser layout
  typedef struct packed {
    logic integrating;
    logic saturated;
  } pidaw_flags_t;

endpackage

`default_nettype wire

[sv/pidaw_core.sv]
// ----------------------------------------------------------------------------
// pidaw_core
// single-pass pid arithmetic: error, anti-windup, integral, sum and clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidaw_core #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  pidaw_pkg::pidaw_cfg_t           cfg_i,
  input  logic        [DATA_WIDTH-1:0]    feedback_i,
  input  logic        [DATA_WIDTH-1:0]    setpoint_i,
  input  logic        [DATA_WIDTH-1:0]    feedforward_i,
  input  logic        [31:0]              integral_i,
  input  logic        [DATA_WIDTH:0]      prev_error_i,
  input  logic        [DATA_WIDTH-1:0]    prev_output_i,
  output logic        [DATA_WIDTH-1:0]    drive_o,
  output pidaw_pkg::pidaw_flags_t         flags_o,
  output logic        [31:0]              integral_o,
  output logic        [DATA_WIDTH:0]      error_o
);
  import pidaw_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned EW = W + 1;
  localparam int unsigned CW = ((EW > 17) ? EW : 17) + 1;
  localparam int unsigned SW = ((EW > 32) ? EW : 32) + 1;
  localparam int unsigned DW = EW + 1;
  localparam int unsigned AW = (((W + 18) > 48) ? (W + 18) : 48) + 2;
  localparam int unsigned QW = AW - 8;

  logic signed [EW-1:0]   err_raw;
  logic signed [EW-1:0]   err;
  logic signed [CW-1:0]   err_raw_c;
  logic signed [CW-1:0]   err_c;
  logic signed [CW-1:0]   db_c;
  logic signed [CW-1:0]   thr_c;
  logic signed [CW-1:0]   pout_c;
  logic signed [CW-1:0]   obnd_c;
  logic                   in_deadband;
  logic                   separated;
  logic                   isolated;
  logic                   integ;
  logic signed [SW-1:0]   isum_ext;
  logic        [31:0]     isum_sat;
  logic        [31:0]     isum_upd;
  logic signed [32:0]     isum_c;
  logic signed [32:0]     ibnd_c;
  logic signed [32:0]     ibnd_neg;
  logic signed [31:0]     isum_new;
  logic signed [15:0]     gp;
  logic signed [15:0]     gi;
  logic signed [15:0]     gd;
  logic signed [DW-1:0]   diff;
  logic signed [EW+15:0]  prod_p;
  logic signed [DW+15:0]  prod_d;
  logic signed [47:0]     prod_i;
  logic signed [AW-1:0]   acc;
  logic signed [QW-1:0]   quot;
  logic        [QW-1:0]   obnd_q;
  logic        [QW-1:0]   dmax_q;
  logic signed [QW-1:0]   bnd_q;
  logic signed [QW-1:0]   drive_q;
  logic                   sat;

  assign gp = cfg_i.gain_p;
  assign gi = cfg_i.gain_i;
  assign gd = cfg_i.gain_d;

  // error and deadband
  assign err_raw = {setpoint_i[W-1], setpoint_i} - {feedback_i[W-1], feedback_i};
  assign err_raw_c = {{(CW-EW){err_raw[EW-1]}}, err_raw};
  assign db_c  = {{(CW-16){1'b0}}, cfg_i.deadband_width};
  assign in_deadband = cfg_i.mode_flags[ModeDeadband] && (err_raw_c < db_c) &&
                       (err_raw_c > -db_c);
  assign err   = in_deadband ? '0 : err_raw;
  assign err_c = {{(CW-EW){err[EW-1]}}, err};

  // anti-windup decisions
  assign pout_c = {{(CW-W){prev_output_i[W-1]}}, prev_output_i};
  assign obnd_c = {{(CW-15){1'b0}}, cfg_i.output_bound};
  assign separated = cfg_i.mode_flags[ModeSeparate] &&
                     !((pout_c < obnd_c) && (pout_c > -obnd_c));
  assign thr_c = {{(CW-16){1'b0}}, cfg_i.isolate_threshold};
  assign isolated = cfg_i.mode_flags[ModeIsolate] && ((err_c > thr_c) || (err_c < -thr_c));
  assign integ = !separated && !isolated;

  // integral update with 32-bit saturation
  assign isum_ext = {{(SW-32){integral_i[31]}}, integral_i} + {{(SW-EW){err[EW-1]}}, err};

  always_comb begin
    isum_sat = isum_ext[31:0];
    if (!isum_ext[SW-1] && (|isum_ext[SW-2:31])) begin
      isum_sat = {1'b0, {31{1'b1}}};
    end else if (isum_ext[SW-1] && !(&isum_ext[SW-2:31])) begin
      isum_sat = {1'b1, {31{1'b0}}};
    end
  end

  assign isum_upd = integ ? isum_sat : integral_i;
  assign isum_c   = {isum_upd[31], isum_upd};
  assign ibnd_c   = {2'b00, cfg_i.integral_bound};
  assign ibnd_neg = -ibnd_c;

  always_comb begin
    isum_new = isum_upd;
    if (cfg_i.mode_flags[ModeIntClamp]) begin
      if (isum_c > ibnd_c) begin
        isum_new = ibnd_c[31:0];
      end else if (isum_c < ibnd_neg) begin
        isum_new = ibnd_neg[31:0];
      end
    end
  end

  // p, i and d products, all in q.8
  assign diff   = {err[EW-1], err} - {prev_error_i[EW-1], prev_error_i};
  assign prod_p = err * gp;
  assign prod_d = diff * gd;
  assign prod_i = isum_new * gi;

  always_comb begin
    acc = {{(AW-EW-16){prod_p[EW+15]}}, prod_p} + {{(AW-DW-16){prod_d[DW+15]}}, prod_d};
    if (!isolated) begin
      acc = acc + {{(AW-48){prod_i[47]}}, prod_i};
    end
    if (cfg_i.mode_flags[ModeFeedfwd]) begin
      acc = acc + {{(AW-W-8){feedforward_i[W-1]}}, feedforward_i, 8'h00};
    end
    acc = acc + AW'(128);
  end

  // floor of the shifted sum gives round half up
  assign quot = acc[AW-1:8];

  assign obnd_q = {{(QW-15){1'b0}}, cfg_i.output_bound};
  assign dmax_q = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  assign bnd_q  = (obnd_q < dmax_q) ? obnd_q : dmax_q;

  always_comb begin
    drive_q = quot;
    sat     = 1'b0;
    if (quot > bnd_q) begin
      drive_q = bnd_q;
      sat     = 1'b1;
    end else if (quot < -bnd_q) begin
      drive_q = -bnd_q;
      sat     = 1'b1;
    end
  end

  assign drive_o             = drive_q[W-1:0];
  assign flags_o.saturated   = sat;
  assign flags_o.integrating = integ;
  assign integral_o          = isum_new;
  assign error_o             = err;

endmodule

`default_nettype wire

[sv/pid_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// positional fixed-point pid controller with anti-windup options
// ----------------------------------------------------------------------------
// The slave stream carries one sample per word: feedback, setpoint and
// feedforward value. The master stream returns one word per sample with the
// clamped drive in tdata and the saturated and integrating flags in tuser.
// Gains, deadband, isolation threshold, bounds and mode flags are written
// through the cfg port; the user must write them only while no sample is in
// flight, and the block itself does not enforce this. An accepted sample is
// registered in the input register, processed combinationally and moved into
// the result register once that register is free or being taken. One sample
// is taken per cycle while the receiver does not stall; the integral, last
// error and last drive update as a sample leaves, for the next one to use.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more sample; tready drops only when both are full.
// Reset clears the integral, the last error and the last drive, empties both
// registers and loads the default configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_antiwindup #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // fields from bit 0: feedback, setpoint, feedforward_value
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // fields from bit 0: drive
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // fields from bit 0: saturated, integrating
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we_i,
  input  logic [pidaw_pkg::CfgAddrWidth-1:0]     cfg_addr_i,
  input  logic [pidaw_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);
  import pidaw_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  pidaw_cfg_t     cfg_q;
  logic           in_valid_q;
  logic [W-1:0]   fb_q;
  logic [W-1:0]   sp_q;
  logic [W-1:0]   ff_q;
  logic           out_valid_q;
  logic [W-1:0]   drive_q;
  pidaw_flags_t   flags_q;
  logic [31:0]    integral_q;
  logic [W:0]     prev_err_q;
  logic [W-1:0]   prev_out_q;

  logic           in_accept;
  logic           advance;
  logic [W-1:0]   drive_d;
  pidaw_flags_t   flags_d;
  logic [31:0]    integral_d;
  logic [W:0]     err_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p            <= '0;
      cfg_q.gain_i            <= '0;
      cfg_q.gain_d            <= '0;
      cfg_q.deadband_width    <= '0;
      cfg_q.isolate_threshold <= '1;
      cfg_q.integral_bound    <= '1;
      cfg_q.output_bound      <= '1;
      cfg_q.mode_flags        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GAIN_P:      cfg_q.gain_p            <= cfg_wdata_i[15:0];
        CFG_GAIN_I:      cfg_q.gain_i            <= cfg_wdata_i[15:0];
        CFG_GAIN_D:      cfg_q.gain_d            <= cfg_wdata_i[15:0];
        CFG_DEADBAND:    cfg_q.deadband_width    <= cfg_wdata_i[15:0];
        CFG_ISOLATE_THR: cfg_q.isolate_threshold <= cfg_wdata_i[15:0];
        CFG_INT_BOUND:   cfg_q.integral_bound    <= cfg_wdata_i[30:0];
        CFG_OUT_BOUND:   cfg_q.output_bound      <= cfg_wdata_i[14:0];
        CFG_MODE:        cfg_q.mode_flags        <= cfg_wdata_i[4:0];
        default:         cfg_q                   <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fb_q <= s_axis_tdata[W-1:0];
      sp_q <= s_axis_tdata[2*W-1:W];
      ff_q <= s_axis_tdata[3*W-1:2*W];
    end
  end

  pidaw_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .cfg_i         (cfg_q),
    .feedback_i    (fb_q),
    .setpoint_i    (sp_q),
    .feedforward_i (ff_q),
    .integral_i    (integral_q),
    .prev_error_i  (prev_err_q),
    .prev_output_i (prev_out_q),
    .drive_o       (drive_d),
    .flags_o       (flags_d),
    .integral_o    (integral_d),
    .error_o       (err_d)
  );

  // controller state, updated once per processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_err_q <= '0;
      prev_out_q <= '0;
    end else if (advance) begin
      integral_q <= integral_d;
      prev_err_q <= err_d;
      prev_out_q <= drive_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
      flags_q <= flags_d;
    end
  end

  always_comb begin
    m_axis_tdata        = '0;
    m_axis_tdata[W-1:0] = drive_q;
  end

  assign m_axis_tuser  = {flags_q.integrating, flags_q.saturated};
  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

[sv/pidaw_checker.sv]
// ----------------------------------------------------------------------------
// pidaw_checker
// port-level checks of the pid controller streams, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_antiwindup_defines.svh"

module pidaw_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input  logic [1:0]                        m_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  // a stalled result word holds
  `PIDAW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // a result word leaves only when taken
  `PIDAW_ASSERT_IMP(a_out_drop, clk_i, rst_ni, $fell(m_axis_tvalid), $past(m_axis_tready), "result word dropped without handshake")

  // every new result comes from an accepted sample that passed the input register
  `PIDAW_ASSERT_IMP(a_out_origin, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result word without accepted sample")

  // the input side only stalls when the result register is full
  `PIDAW_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid, "input stalled with empty result register")

endmodule

bind pid_controller_antiwindup pidaw_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pidaw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
